>>> design/ttu_pkg.sv
// ---------------------------------------------------------------------------
// ttu_pkg
// Shared constants and types for the Taylor series trigonometric unit.
// ---------------------------------------------------------------------------
package ttu_pkg;

  localparam int FRAC_BITS = 28;
  localparam int ACC_WIDTH = 48;
  localparam int ANGLE_W   = 32;
  localparam int OP_W      = 3;
  localparam int MAX_TERMS = 64;
  localparam int INNER_W   = 64;

  localparam logic [63:0] INNER_MAX  = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] HALFPI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] HALFPI_RND = 64'd1 << (61 - FRAC_BITS);
  localparam logic [63:0] HALFPI_SUM = HALFPI_Q62 + HALFPI_RND;
  localparam logic [63:0] HALFPI     = HALFPI_SUM >> (62 - FRAC_BITS);
  localparam logic [63:0] ONE        = 64'd1 << FRAC_BITS;

  localparam logic [OP_W-1:0] OP_SIN = 3'd0;
  localparam logic [OP_W-1:0] OP_COS = 3'd1;
  localparam logic [OP_W-1:0] OP_TAN = 3'd2;
  localparam logic [OP_W-1:0] OP_COT = 3'd3;
  localparam logic [OP_W-1:0] OP_SEC = 3'd4;
  localparam logic [OP_W-1:0] OP_CSC = 3'd5;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] d;
  } div_req_t;

  typedef struct packed {
    logic [63:0] q;
    logic        clip;
  } div_rsp_t;

endpackage

>>> design/ttu_if.sv
// ---------------------------------------------------------------------------
// ttu_in_if / ttu_out_if
// Valid/ready channels for the trigonometric unit.
// ---------------------------------------------------------------------------
interface ttu_in_if;
  logic                        valid;
  logic                        ready;
  logic [ttu_pkg::OP_W-1:0]    op;
  logic signed [ttu_pkg::ANGLE_W-1:0] angle;
  modport source (output valid, output op, output angle, input ready);
  modport sink   (input valid, input op, input angle, output ready);
endinterface

interface ttu_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ttu_pkg::ACC_WIDTH-1:0] value;
  logic                                 divided_by_zero;
  logic                                 saturated;
  modport source (output valid, output value, output divided_by_zero, output saturated,
                  input ready);
  modport sink   (input valid, input value, input divided_by_zero, input saturated,
                  output ready);
endinterface

>>> design/taylor_trig_unit.sv
// ---------------------------------------------------------------------------
// taylor_trig_unit
// Fixed-point sin, cos, tan, cot, sec and csc from a Taylor sine series.
// ---------------------------------------------------------------------------
// channel  dir  payload
// in_      in   op[2:0], angle[31:0] signed Q.28
// out_     out  value[47:0] signed Q.28, divided_by_zero, saturated
//
// Each series step takes one multiply and one division; up to 64 steps
// a series, one or two series an item, plus one division for ratio ops.
// All of these run on the shared multiplier and divider.
// in_ready is low while an item is at work or its result waits; rst_n
// clears the sequencer.
// ---------------------------------------------------------------------------
module taylor_trig_unit (
  input logic clk,
  input logic rst_n,
  ttu_in_if.sink    in_ch,
  ttu_out_if.source out_ch
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SQ    = 9'b000000010,
    S_SQW   = 9'b000000100,
    S_TMUL  = 9'b000001000,
    S_TMW   = 9'b000010000,
    S_TDIV  = 9'b000100000,
    S_NEXT  = 9'b001000000,
    S_RATIO = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t      st_r, st_nxt;
  logic [2:0]  op_r;
  logic signed [63:0] a_r, term_r, sum_r, s_r, c_r;
  logic [63:0] sq_r;
  logic [7:0]  n_r;
  logic [6:0]  it_r;
  logic        pass_r;   // 0: sine series, 1: cosine series
  logic        clip_r, dz_r;
  logic        rdiv_r;
  logic        rneg_r;

  logic         m_start, m_done;
  logic [63:0]  m_x, m_y;
  logic [127:0] m_p;
  logic         d_start, d_done;
  ttu_pkg::div_req_t d_req;
  ttu_pkg::div_rsp_t d_rsp;

  ttu_mul u_mul (.clk, .rst_n, .start(m_start), .x(m_x), .y(m_y), .done(m_done), .p(m_p));
  ttu_div u_div (.clk, .rst_n, .start(d_start), .req(d_req), .done(d_done), .rsp(d_rsp));

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? 64'd0 - v : v;
  endfunction

  logic signed [63:0] num, den, nsum, q_s, a_in;
  logic [63:0] mag_num;
  logic [15:0] kk;
  logic signed [63:0] vfin;
  logic signed [63:0] omax, omin;

  always_comb begin
    case (op_r)
      ttu_pkg::OP_TAN: begin num = s_r; den = c_r; end
      ttu_pkg::OP_COT: begin num = c_r; den = s_r; end
      ttu_pkg::OP_SEC: begin num = ttu_pkg::ONE; den = c_r; end
      default:         begin num = ttu_pkg::ONE; den = s_r; end
    endcase
    mag_num = mag(num);
    kk   = ({8'd0, n_r} + 16'd1) * ({8'd0, n_r} + 16'd2);
    a_in = pass_r ? a_r + $signed(ttu_pkg::HALFPI) : a_r;
    m_x  = (st_r == S_SQ) ? mag(a_in) : mag(term_r);
    m_y  = (st_r == S_SQ) ? mag(a_in) : sq_r;
    m_start = (st_r == S_SQ) || (st_r == S_TMUL);
    d_start = m_done && (st_r == S_TMW) || (st_r == S_RATIO && !rdiv_r && den != 0);
    if (st_r == S_RATIO) begin
      d_req.hi = mag_num >> (64 - ttu_pkg::FRAC_BITS);
      d_req.lo = mag_num << ttu_pkg::FRAC_BITS;
      d_req.d  = mag(den);
    end else begin
      d_req.hi = m_p[127:64];
      d_req.lo = m_p[63:0];
      d_req.d  = {48'd0, kk} << ttu_pkg::FRAC_BITS;
    end
    q_s  = term_r > 0 ? -$signed(d_rsp.q) : $signed(d_rsp.q);
    nsum = sum_r + q_s;
    omax = $signed((64'd1 << (ttu_pkg::ACC_WIDTH - 1)) - 64'd1);
    omin = -omax - 64'sd1;
    case (op_r)
      ttu_pkg::OP_SIN: vfin = s_r;
      ttu_pkg::OP_COS: vfin = c_r;
      default:         vfin = sum_r;
    endcase
    st_nxt = st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (in_ch.valid) begin
          op_r   <= in_ch.op;
          clip_r <= 1'b0;
          dz_r   <= 1'b0;
          s_r    <= '0;
          c_r    <= '0;
          a_r    <= {{32{in_ch.angle[31]}}, in_ch.angle};
          if (in_ch.op > ttu_pkg::OP_CSC) begin
            sum_r <= '0;
            st_r  <= S_OUT;
          end else begin
            pass_r <= (in_ch.op == ttu_pkg::OP_COS) || (in_ch.op == ttu_pkg::OP_SEC);
            st_r   <= S_SQ;
          end
        end
        S_SQ: begin
          a_r <= a_in;
          term_r <= a_in;
          sum_r  <= a_in;
          st_r <= S_SQW;
        end
        S_SQW: if (m_done) begin
          sq_r <= m_p[ttu_pkg::FRAC_BITS+63:ttu_pkg::FRAC_BITS];
          n_r  <= 8'd1;
          it_r <= '0;
          st_r <= S_NEXT;
        end
        S_NEXT: begin
          if (term_r != 0 && it_r != 7'(ttu_pkg::MAX_TERMS)) begin
            st_r <= S_TMUL;
          end else begin
            if (pass_r) c_r <= sum_r; else s_r <= sum_r;
            if (pass_r && op_r != ttu_pkg::OP_TAN && op_r != ttu_pkg::OP_COT
                || !pass_r && (op_r == ttu_pkg::OP_SIN || op_r == ttu_pkg::OP_CSC)
                || pass_r) begin
              if (op_r == ttu_pkg::OP_SIN || op_r == ttu_pkg::OP_COS) st_r <= S_OUT;
              else begin rdiv_r <= 1'b0; st_r <= S_RATIO; end
            end else begin
              pass_r <= 1'b1;
              a_r    <= a_r;
              st_r   <= S_SQ;
            end
          end
        end
        S_TMUL: st_r <= S_TMW;
        S_TMW: if (m_done) st_r <= S_TDIV;
        S_TDIV: if (d_done) begin
          term_r <= q_s;
          clip_r <= clip_r | d_rsp.clip;
          if (nsum > $signed(ttu_pkg::INNER_MAX)) begin
            sum_r <= ttu_pkg::INNER_MAX; clip_r <= 1'b1;
          end else if (nsum < -$signed(ttu_pkg::INNER_MAX)) begin
            sum_r <= -$signed(ttu_pkg::INNER_MAX); clip_r <= 1'b1;
          end else sum_r <= nsum;
          n_r  <= n_r + 8'd2;
          it_r <= it_r + 7'd1;
          st_r <= S_NEXT;
        end
        S_RATIO: begin
          if (!rdiv_r) begin
            rneg_r <= num[63] != den[63];
            if (den == 0) begin
              dz_r <= 1'b1; clip_r <= 1'b1;
              sum_r <= num[63] ? -$signed(ttu_pkg::INNER_MAX) : ttu_pkg::INNER_MAX;
              st_r <= S_OUT;
            end else rdiv_r <= 1'b1;
          end else if (d_done) begin
            clip_r <= clip_r | d_rsp.clip;
            sum_r  <= rneg_r ? -$signed(d_rsp.q) : $signed(d_rsp.q);
            st_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.divided_by_zero <= dz_r;
            if (vfin > omax) begin
              out_ch.value <= omax[ttu_pkg::ACC_WIDTH-1:0]; out_ch.saturated <= 1'b1;
            end else if (vfin < omin) begin
              out_ch.value <= omin[ttu_pkg::ACC_WIDTH-1:0]; out_ch.saturated <= 1'b1;
            end else begin
              out_ch.value <= vfin[ttu_pkg::ACC_WIDTH-1:0]; out_ch.saturated <= clip_r;
            end
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= st_nxt;
      endcase
    end
  end

  assign in_ch.ready = (st_r == S_IDLE);
endmodule

>>> design/ttu_mul.sv
// ---------------------------------------------------------------------------
// ttu_mul
// 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// ---------------------------------------------------------------------------
module ttu_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [63:0]  x,
  input  logic [63:0]  y,
  output logic         done,
  output logic [127:0] p
);
  logic [63:0]  x_r, y_r;
  logic [127:0] acc_r;
  logic [2:0]   cnt_r;
  logic         busy_r;
  logic [31:0]  xa, ya;
  logic [63:0]  pp;
  logic [127:0] sh;

  always_comb begin
    xa = cnt_r[1] ? x_r[63:32] : x_r[31:0];
    ya = cnt_r[0] ? y_r[63:32] : y_r[31:0];
    pp = {32'd0, xa} * {32'd0, ya};
    sh = {64'd0, pp} << (7'd32 * ({6'd0, cnt_r[1]} + {6'd0, cnt_r[0]}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= x;
        y_r    <= y;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_r + sh;
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign p = acc_r;
endmodule

>>> design/ttu_div.sv
// ---------------------------------------------------------------------------
// ttu_div
// Restoring divider for a 128-bit dividend by a 64-bit divisor, one bit a cycle.
// ---------------------------------------------------------------------------
module ttu_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ttu_pkg::div_req_t   req,
  output logic                done,
  output ttu_pkg::div_rsp_t   rsp
);
  logic [64:0] r_r;
  logic [63:0] lo_r, q_r, d_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [64:0] rs;
  logic        ge;

  always_comb begin
    rs = {r_r[63:0], lo_r[63]};
    ge = rs >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (req.hi >= req.d) begin
          done     <= 1'b1;
          rsp.q    <= ttu_pkg::INNER_MAX;
          rsp.clip <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          r_r    <= {1'b0, req.hi};
          lo_r   <= req.lo;
          d_r    <= req.d;
          q_r    <= '0;
          cnt_r  <= '0;
        end
      end else if (busy_r) begin
        r_r   <= ge ? rs - {1'b0, d_r} : rs;
        lo_r  <= {lo_r[62:0], 1'b0};
        q_r   <= {q_r[62:0], ge};
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
          if ({q_r[62:0], ge} > ttu_pkg::INNER_MAX) begin
            rsp.q    <= ttu_pkg::INNER_MAX;
            rsp.clip <= 1'b1;
          end else begin
            rsp.q    <= {q_r[62:0], ge};
            rsp.clip <= 1'b0;
          end
        end
      end
    end
  end
endmodule
